/* rtl/rbr_pkg.sv */
// ----------------------------------------------------------------------------
// rbr_pkg: shared types and constants for the retry backoff recovery block
// Holds the recovery state codes, register indexes, the configuration
// bundle and the words that travel between the pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

package rbr_pkg;

   // Field widths of the event and result words.
   localparam int DELAY_BITS    = 16;
   localparam int VALUE_BITS    = 16;
   localparam int COUNT_BITS    = 8;
   localparam int HINT_BITS     = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam int REQ_DATA_BITS = 64;
   localparam int RSP_DATA_BITS = 24;

   // Mask applied to the delay on the way out.
   localparam logic [VALUE_BITS-1:0] DELAY_MASK =
      (DELAY_BITS >= VALUE_BITS) ? {VALUE_BITS{1'b1}}
                                 : VALUE_BITS'((64'd1 << DELAY_BITS) - 64'd1);

   // Recovery state reported with each result.
   typedef enum logic [1:0] {
      ST_NO_NETWORK   = 2'd0,
      ST_CIRCUIT_OPEN = 2'd1,
      ST_BACKING_OFF  = 2'd2
   } rec_state_type;

   // Configuration register indexes.
   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_INITIAL_BACKOFF = 3'd0,
      CSR_MAX_BACKOFF     = 3'd1,
      CSR_MAX_JITTER      = 3'd2,
      CSR_TRIP_FAILURES   = 3'd3,
      CSR_CIRCUIT_FLOOR   = 3'd4
   } csr_index_type;

   // Configuration bundle handed to the datapath.
   typedef struct packed {
      logic [VALUE_BITS-1:0] initial_backoff;
      logic [VALUE_BITS-1:0] max_backoff;
      logic [VALUE_BITS-1:0] max_jitter;
      logic [COUNT_BITS-1:0] trip_failures;
      logic [VALUE_BITS-1:0] circuit_floor;
   } cfg_type;

   // Classified event leaving the first stage.
   typedef struct packed {
      rec_state_type         state;
      logic [COUNT_BITS-1:0] shift;
      logic [VALUE_BITS-1:0] jitter;
      logic [HINT_BITS-1:0]  hint;
   } event_type;

   // Event with its delay worked out so far.
   typedef struct packed {
      rec_state_type         state;
      logic [VALUE_BITS-1:0] delay;
      logic [VALUE_BITS-1:0] jitter;
      logic [HINT_BITS-1:0]  hint;
   } delay_type;

endpackage

`default_nettype wire

/* rtl/rbr_backoff.sv */
// ----------------------------------------------------------------------------
// rbr_backoff: exponential backoff and jitter stages
// Two register stages: the saturating doubling of the initial delay, then
// the jitter addition clamped to the maximum. Each stage holds its word
// until the next one can take it.
// ----------------------------------------------------------------------------
`default_nettype none

module rbr_backoff
   import rbr_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire logic      in_valid,
   output logic           in_ready,
   input  wire event_type in_word,
   output logic           out_valid,
   input  wire logic      out_ready,
   output delay_type      out_word
);

   logic                   dbl_valid_ff;
   delay_type              dbl_word_ff;
   delay_type              dbl_word_in;
   logic                   jit_valid_ff;
   delay_type              jit_word_ff;
   delay_type              jit_word_in;
   logic                   dbl_ready;
   logic                   jit_ready;
   logic [2*VALUE_BITS-1:0] shifted;
   logic                   shift_big;
   logic [VALUE_BITS:0]    jit_sum;

   // A stage takes a new word when it is empty or its word moves on.
   assign jit_ready = !jit_valid_ff || out_ready;
   assign dbl_ready = !dbl_valid_ff || jit_ready;
   assign in_ready  = dbl_ready;

   // Doubling: initial << (count - 1), saturated at the maximum; an initial delay at or above it is kept.
   // A zero initial delay stays zero however often it is doubled.
   always_comb begin
      shift_big = (in_word.shift[COUNT_BITS-1:4] != '0);
      shifted   = {{VALUE_BITS{1'b0}}, cfg.initial_backoff} << in_word.shift[3:0];
      dbl_word_in.state  = in_word.state;
      dbl_word_in.jitter = in_word.jitter;
      dbl_word_in.hint   = in_word.hint;
      if (cfg.initial_backoff >= cfg.max_backoff) begin
         dbl_word_in.delay = cfg.initial_backoff;
      end else if ((shift_big && cfg.initial_backoff != '0) ||
                   shifted >= {{VALUE_BITS{1'b0}}, cfg.max_backoff}) begin
         dbl_word_in.delay = cfg.max_backoff;
      end else begin
         dbl_word_in.delay = shifted[VALUE_BITS-1:0];
      end
   end

   // Jitter: added only below the maximum, and never past it.
   always_comb begin
      jit_sum     = {1'b0, dbl_word_ff.delay} + {1'b0, dbl_word_ff.jitter};
      jit_word_in = dbl_word_ff;
      if (dbl_word_ff.delay < cfg.max_backoff) begin
         if (jit_sum > {1'b0, cfg.max_backoff}) begin
            jit_word_in.delay = cfg.max_backoff;
         end else begin
            jit_word_in.delay = jit_sum[VALUE_BITS-1:0];
         end
      end
   end

   // Valid bits of both stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         dbl_valid_ff <= 1'b0;
         jit_valid_ff <= 1'b0;
      end else begin
         if (dbl_ready) begin
            dbl_valid_ff <= in_valid;
         end
         if (jit_ready) begin
            jit_valid_ff <= dbl_valid_ff;
         end
      end
   end

   // Stage words.
   always_ff @(posedge clock) begin
      if (dbl_ready && in_valid) begin
         dbl_word_ff <= dbl_word_in;
      end
      if (jit_ready && dbl_valid_ff) begin
         jit_word_ff <= jit_word_in;
      end
   end

   assign out_valid = jit_valid_ff;
   assign out_word  = jit_word_ff;

endmodule

`default_nettype wire

/* rtl/retry_backoff_recovery.sv */
// ----------------------------------------------------------------------------
// retry_backoff_recovery: recovery action and delay for a failure event
// Classifies each failure as no-network, circuit-open or backing-off and
// works out the wait before the next attempt: saturating exponential
// backoff, clamped jitter and an overriding server hint.
//
//   Group  Direction  Carries
//   req_   in         failure event word (stream)
//   rsp_   out        recovery decision word (stream)
//   csr_   in         register writes (index, data)
//
// Four register stages: classify, double, add jitter, apply hint and
// select. One word enters every cycle while rsp_ does not stall.
// Reset empties the pipeline and loads the register defaults.
// A stall on rsp_ backs up stage by stage; no word is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module retry_backoff_recovery
   import rbr_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // is_path_failure[0], failure_count[8:1], path_viable[9],
   // jitter_seconds[25:10], server_hint[57:26], zero fill [63:58]
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // next_state[1:0], delay_seconds[17:2], counts_failure[18], zero [23:19]
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   input  wire logic                     csr_we,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cfg_type               cfg_ff;
   logic                  cls_valid_ff;
   event_type             cls_word_ff;
   event_type             cls_word_in;
   logic                  cls_ready;
   logic                  core_in_ready;
   logic                  core_valid;
   logic                  core_ready;
   delay_type             core_word;
   logic                  rsp_valid_ff;
   rec_state_type         rsp_state_ff;
   logic [VALUE_BITS-1:0] rsp_delay_ff;
   rec_state_type         rsp_state_in;
   logic [VALUE_BITS-1:0] rsp_delay_in;

   logic                  ev_path_fail;
   logic [COUNT_BITS-1:0] ev_count;
   logic                  ev_viable;
   logic [VALUE_BITS-1:0] ev_jitter;
   logic [HINT_BITS-1:0]  ev_hint;

   // Unpack the event word.
   assign ev_path_fail = req_tdata[0];
   assign ev_count     = req_tdata[8:1];
   assign ev_viable    = req_tdata[9];
   assign ev_jitter    = req_tdata[25:10];
   assign ev_hint      = req_tdata[57:26];

   // Register writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.initial_backoff <= VALUE_BITS'(1);
         cfg_ff.max_backoff     <= VALUE_BITS'(300);
         cfg_ff.max_jitter      <= VALUE_BITS'(30);
         cfg_ff.trip_failures   <= COUNT_BITS'(8);
         cfg_ff.circuit_floor   <= VALUE_BITS'(600);
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_INITIAL_BACKOFF: cfg_ff.initial_backoff <= csr_wdata[VALUE_BITS-1:0];
            CSR_MAX_BACKOFF:     cfg_ff.max_backoff     <= csr_wdata[VALUE_BITS-1:0];
            CSR_MAX_JITTER:      cfg_ff.max_jitter      <= csr_wdata[VALUE_BITS-1:0];
            CSR_TRIP_FAILURES:   cfg_ff.trip_failures   <= csr_wdata[COUNT_BITS-1:0];
            CSR_CIRCUIT_FLOOR:   cfg_ff.circuit_floor   <= csr_wdata[VALUE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Stage handshakes: a stage loads when empty or when its word leaves.
   assign core_ready = !rsp_valid_ff || rsp_tready;
   assign cls_ready  = !cls_valid_ff || core_in_ready;
   assign req_tready = cls_ready;

   // Classification, shift count and jitter clamp.
   always_comb begin
      cls_word_in.hint = ev_hint;
      if (ev_path_fail || !ev_viable) begin
         cls_word_in.state = ST_NO_NETWORK;
      end else if (ev_count >= cfg_ff.trip_failures) begin
         cls_word_in.state = ST_CIRCUIT_OPEN;
      end else begin
         cls_word_in.state = ST_BACKING_OFF;
      end
      // A count of zero doubles as often as a count of one.
      cls_word_in.shift  = (ev_count == '0) ? '0 : ev_count - COUNT_BITS'(1);
      cls_word_in.jitter = (ev_jitter > cfg_ff.max_jitter) ? cfg_ff.max_jitter : ev_jitter;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cls_valid_ff <= 1'b0;
      end else if (cls_ready) begin
         cls_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (cls_ready && req_tvalid) begin
         cls_word_ff <= cls_word_in;
      end
   end

   // Doubling and jitter stages.
   rbr_backoff u_backoff (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (cls_valid_ff),
      .in_ready  (core_in_ready),
      .in_word   (cls_word_ff),
      .out_valid (core_valid),
      .out_ready (core_ready),
      .out_word  (core_word)
   );

   // Server hint override and final selection by state.
   always_comb begin
      rsp_state_in = core_word.state;
      case (core_word.state)
         ST_NO_NETWORK: begin
            rsp_delay_in = '0;
         end
         ST_CIRCUIT_OPEN: begin
            rsp_delay_in = cfg_ff.circuit_floor;
         end
         ST_BACKING_OFF: begin
            if (core_word.hint > {{(HINT_BITS-VALUE_BITS){1'b0}}, core_word.delay}) begin
               if (core_word.hint > {{(HINT_BITS-VALUE_BITS){1'b0}}, cfg_ff.max_backoff}) begin
                  rsp_delay_in = cfg_ff.max_backoff;
               end else begin
                  rsp_delay_in = core_word.hint[VALUE_BITS-1:0];
               end
            end else begin
               rsp_delay_in = core_word.delay;
            end
         end
         default: begin
            rsp_delay_in = '0;
         end
      endcase
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (core_ready) begin
         rsp_valid_ff <= core_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (core_ready && core_valid) begin
         rsp_state_ff <= rsp_state_in;
         rsp_delay_ff <= rsp_delay_in & DELAY_MASK;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, (rsp_state_ff != ST_NO_NETWORK), rsp_delay_ff, rsp_state_ff};

endmodule

`default_nettype wire

/* verif/tb_retry_backoff_recovery.sv */
// ----------------------------------------------------------------------------
// tb_retry_backoff_recovery: self-checking bench for the recovery block
// Streams failure events into the block and predicts every decision word
// from its own copy of the registers. Random idling on both sides, register
// changes between phases (extremes included) and a field-by-field check of
// each result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_retry_backoff_recovery
   import rbr_pkg::*;
();

   localparam int CLK_HALF      = 5;
   localparam int RESET_CYCLES  = 9;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_EVENTS  = 150;
   localparam int CALM_STRETCH  = 50;
   localparam int GAP_MAX       = 16;
   localparam int IDLE_LIMIT    = 2000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int REPORT_MAX    = 10;

   // Register indexes that no register answers to.
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SPARE_FIRST = 3'd5;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SPARE_LAST  = 3'd7;

   // One predicted decision.
   typedef struct {
      rec_state_type         state;
      logic [VALUE_BITS-1:0] delay;
      logic                  counts;
   } decision_type;

   // Holds the register copy, predicts decisions and checks the block's words.
   class decision_book;
      logic [VALUE_BITS-1:0] initial_backoff = 16'd1;
      logic [VALUE_BITS-1:0] max_backoff     = 16'd300;
      logic [VALUE_BITS-1:0] max_jitter      = 16'd30;
      logic [COUNT_BITS-1:0] trip_failures   = 8'd8;
      logic [VALUE_BITS-1:0] circuit_floor   = 16'd600;
      decision_type          due_decisions[$];
      int unsigned           mismatches;
      int unsigned           strays;
      int unsigned           reported;
      int unsigned           checked;
      int unsigned           per_state[3];

      function void set_register(logic [CSR_ADDR_BITS-1:0] index,
                                 logic [CSR_DATA_BITS-1:0] value);
         case (index)
            CSR_INITIAL_BACKOFF: initial_backoff = value;
            CSR_MAX_BACKOFF:     max_backoff     = value;
            CSR_MAX_JITTER:      max_jitter      = value;
            CSR_TRIP_FAILURES:   trip_failures   = value[COUNT_BITS-1:0];
            CSR_CIRCUIT_FLOOR:   circuit_floor   = value;
            default: ;
         endcase
      endfunction

      // Exponential backoff, then clamped jitter, then the server hint.
      function logic [VALUE_BITS-1:0] backoff_delay(logic [COUNT_BITS-1:0] count,
                                                     logic [VALUE_BITS-1:0] jitter,
                                                     logic [HINT_BITS-1:0] hint);
         logic [31:0] span;
         logic [31:0] ceiling;
         logic [31:0] jit;
         logic [31:0] room;
         int unsigned steps;
         span    = 32'(initial_backoff);
         ceiling = 32'(max_backoff);
         jit     = 32'((jitter > max_jitter) ? max_jitter : jitter);
         steps   = (count == 0) ? 1 : int'(count);
         for (int unsigned i = 1; i < steps && span < ceiling; i++) begin
            span = (span > ceiling / 2) ? ceiling : span * 2;
         end
         if (span < ceiling) begin
            room = ceiling - span;
            span = span + ((jit < room) ? jit : room);
         end
         if (hint > span) begin
            span = (hint > ceiling) ? ceiling : hint;
         end
         return span[VALUE_BITS-1:0];
      endfunction

      function decision_type predict_decision(logic [REQ_DATA_BITS-1:0] word);
         decision_type d;
         logic                  path;
         logic                  viable;
         logic [COUNT_BITS-1:0] count;
         logic [VALUE_BITS-1:0] jitter;
         logic [HINT_BITS-1:0]  hint;
         path   = word[0];
         count  = word[8:1];
         viable = word[9];
         jitter = word[25:10];
         hint   = word[57:26];
         if (path || !viable) begin
            d = '{ST_NO_NETWORK, 16'd0, 1'b0};
         end else if (count >= trip_failures) begin
            d = '{ST_CIRCUIT_OPEN, circuit_floor, 1'b1};
         end else begin
            d = '{ST_BACKING_OFF, backoff_delay(count, jitter, hint), 1'b1};
         end
         d.delay = d.delay & DELAY_MASK;
         return d;
      endfunction

      function void note_event(logic [REQ_DATA_BITS-1:0] word);
         due_decisions.push_back(predict_decision(word));
      endfunction

      function void check_decision(logic [RSP_DATA_BITS-1:0] word);
         decision_type want;
         if (due_decisions.size() == 0) begin
            strays++;
            if (reported < REPORT_MAX) begin
               reported++;
               $display("Unexpected decision word %h with nothing outstanding", word);
            end
            return;
         end
         want = due_decisions.pop_front();
         checked++;
         per_state[int'(want.state)]++;
         if (word[1:0] !== want.state || word[17:2] !== want.delay ||
             word[18] !== want.counts || word[23:19] !== 5'd0) begin
            mismatches++;
            if (reported < REPORT_MAX) begin
               reported++;
               $display("Decision %0d wrong: expected state %0d delay %0d counts %0d,",
                        checked, want.state, want.delay, want.counts);
               $display("   got state %0d delay %0d counts %0d fill %h",
                        word[1:0], word[17:2], word[18], word[23:19]);
            end
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic                     csr_we;
   logic [CSR_ADDR_BITS-1:0] csr_addr;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   decision_book book = new();
   bit           sender_calm;
   bit           receiver_calm;
   int unsigned  idle_cycles;
   int unsigned  events_sent;
   int unsigned  settings_used;

   retry_backoff_recovery dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #CLK_HALF clock = ~clock;

   // Packs the event fields, the path failure flag in the lowest bit.
   function automatic logic [REQ_DATA_BITS-1:0] pack_event(logic path,
                                                           logic [COUNT_BITS-1:0] count,
                                                           logic viable,
                                                           logic [VALUE_BITS-1:0] jitter,
                                                           logic [HINT_BITS-1:0] hint);
      return {6'd0, hint, jitter, viable, count, path};
   endfunction

   // Mostly well-formed backoff events around the trip threshold.
   function automatic logic [REQ_DATA_BITS-1:0] draw_event();
      logic                  path;
      logic                  viable;
      logic [COUNT_BITS-1:0] count;
      logic [VALUE_BITS-1:0] jitter;
      logic [HINT_BITS-1:0]  hint;
      int                    top;
      path   = ($urandom_range(0, 9) == 0);
      viable = ($urandom_range(0, 9) != 0);
      top    = (book.trip_failures >= 254) ? 255 : int'(book.trip_failures) + 1;
      count  = ($urandom_range(0, 9) < 7) ? COUNT_BITS'($urandom_range(0, top))
                                          : COUNT_BITS'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
         0:       jitter = VALUE_BITS'($urandom_range(0, int'(book.max_jitter)));
         1:       jitter = VALUE_BITS'($urandom_range(0, 65535));
         2:       jitter = 16'd0;
         default: jitter = VALUE_BITS'($urandom_range(0, 64));
      endcase
      case ($urandom_range(0, 5))
         3:       hint = $urandom_range(0, 2 * int'(book.max_backoff) + 1);
         4:       hint = $urandom();
         5:       hint = $urandom_range(0, 65535);
         default: hint = 32'd0;
      endcase
      return pack_event(path, count, viable, jitter, hint);
   endfunction

   // Register value in one of three flavours: extremes, small or anything.
   function automatic logic [CSR_DATA_BITS-1:0] draw_setting(int style);
      case (style)
         0: begin
            case ($urandom_range(0, 3))
               0:       return 16'h0000;
               1:       return 16'h0001;
               2:       return 16'h8000;
               default: return 16'hFFFF;
            endcase
         end
         1:       return CSR_DATA_BITS'($urandom_range(0, 1000));
         default: return CSR_DATA_BITS'($urandom_range(0, 65535));
      endcase
   endfunction

   // Picks one of the indexes that no register answers to.
   function automatic logic [CSR_ADDR_BITS-1:0] CSR_INDEX_SPARE();
      return CSR_ADDR_BITS'($urandom_range(int'(CSR_SPARE_FIRST), int'(CSR_SPARE_LAST)));
   endfunction

   // Holds the sender back until every predicted decision has come out.
   task automatic hold_until_drained();
      req_tvalid = 1'b0;
      while (book.due_decisions.size() != 0) @(negedge clock);
   endtask

   // Register write while the block is idle.
   task automatic write_register(logic [CSR_ADDR_BITS-1:0] index,
                                 logic [CSR_DATA_BITS-1:0] value);
      hold_until_drained();
      csr_we    = 1'b1;
      csr_addr  = index;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      book.set_register(index, value);
   endtask

   task automatic write_all(logic [VALUE_BITS-1:0] initial_value,
                            logic [VALUE_BITS-1:0] max_value,
                            logic [VALUE_BITS-1:0] jitter_value,
                            logic [CSR_DATA_BITS-1:0] trip_value,
                            logic [VALUE_BITS-1:0] floor_value);
      write_register(CSR_INITIAL_BACKOFF, initial_value);
      write_register(CSR_MAX_BACKOFF, max_value);
      write_register(CSR_MAX_JITTER, jitter_value);
      write_register(CSR_TRIP_FAILURES, trip_value);
      write_register(CSR_CIRCUIT_FLOOR, floor_value);
      settings_used++;
   endtask

   // Offers one event word after a random gap and waits for the handshake.
   task automatic send_event(logic [REQ_DATA_BITS-1:0] word);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = word;
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      book.note_event(word);
      events_sent++;
      @(negedge clock);
   endtask

   // Result side: random stalls between words, with calm stretches.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = receiver_calm ? 0 : $urandom_range(0, GAP_MAX);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Result checking and the watchdog on handshake activity.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) book.check_decision(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles, %0d decisions outstanding",
                     idle_cycles, book.due_decisions.size());
            $display("tb_retry_backoff_recovery NOT OK");
            $finish;
         end
      end
   end

   // Stimulus, drain and verdict.
   initial begin
      int          style;
      int unsigned failures;
      logic [CSR_DATA_BITS-1:0] trip_value;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      csr_we        = 1'b0;
      csr_addr      = CSR_INITIAL_BACKOFF;
      csr_wdata     = '0;
      sender_calm   = 1'b0;
      receiver_calm = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      settings_used = 1;

      // Directed events on the reset settings.
      send_event(pack_event(1'b1, 8'd3, 1'b1, 16'hFFFF, 32'hFFFF_FFFF));
      send_event(pack_event(1'b0, 8'd0, 1'b0, 16'd0, 32'd0));
      send_event(pack_event(1'b1, 8'd255, 1'b0, 16'd7, 32'd9));
      send_event(pack_event(1'b0, 8'd0, 1'b1, 16'd0, 32'd0));
      send_event(pack_event(1'b0, 8'd1, 1'b1, 16'hFFFF, 32'd0));
      send_event(pack_event(1'b0, 8'd2, 1'b1, 16'd5, 32'd0));
      send_event(pack_event(1'b0, 8'd7, 1'b1, 16'd0, 32'd0));
      send_event(pack_event(1'b0, 8'd8, 1'b1, 16'd3, 32'd1000));
      send_event(pack_event(1'b0, 8'd255, 1'b1, 16'hFFFF, 32'hFFFF_FFFF));
      send_event(pack_event(1'b0, 8'd1, 1'b1, 16'd0, 32'd100));
      send_event(pack_event(1'b0, 8'd1, 1'b1, 16'd0, 32'hFFFF_FFFF));
      send_event(pack_event(1'b0, 8'd7, 1'b1, 16'd30, 32'd50));

      // A zero trip threshold opens the circuit on every viable event without a path failure.
      write_all(16'd1, 16'd300, 16'd30, 16'd0, 16'd600);
      send_event(pack_event(1'b0, 8'd0, 1'b1, 16'd4, 32'd20));
      send_event(pack_event(1'b1, 8'd0, 1'b1, 16'd4, 32'd20));

      // Initial delay above the ceiling: no jitter, a large hint is clamped.
      write_all(16'd500, 16'd300, 16'd30, 16'd8, 16'd600);
      send_event(pack_event(1'b0, 8'd3, 1'b1, 16'd10, 32'd0));
      send_event(pack_event(1'b0, 8'd3, 1'b1, 16'd10, 32'd1000));
      send_event(pack_event(1'b0, 8'd3, 1'b1, 16'd10, 32'd400));

      // Zero ceiling: the initial delay unless a larger hint forces zero.
      write_all(16'd7, 16'd0, 16'd30, 16'd8, 16'd600);
      send_event(pack_event(1'b0, 8'd5, 1'b1, 16'd9, 32'd0));
      send_event(pack_event(1'b0, 8'd5, 1'b1, 16'd9, 32'd8));

      // Writes to unused indexes must leave the settings alone.
      write_all(16'd1, 16'd300, 16'd30, 16'd8, 16'd600);
      write_register(CSR_SPARE_FIRST, 16'hFFFF);
      write_register(CSR_SPARE_LAST, 16'h0000);
      send_event(pack_event(1'b0, 8'd4, 1'b1, 16'd2, 32'd0));
      send_event(pack_event(1'b0, 8'd9, 1'b1, 16'd2, 32'd0));

      // Random phases, each with its own register settings.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0) begin
            write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
         end else if (phase == 1) begin
            write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
         end else begin
            style      = phase % 3;
            trip_value = draw_setting(style);
            if (style == 1) trip_value = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 24))};
            write_all(draw_setting(style), draw_setting(style), draw_setting(style),
                      trip_value, draw_setting(style));
         end
         write_register(CSR_INDEX_SPARE(), 16'($urandom_range(0, 65535)));
         for (int n = 0; n < PHASE_EVENTS; n++) begin
            if (n % CALM_STRETCH == 0) begin
               sender_calm   = ($urandom_range(0, 3) == 0);
               receiver_calm = ($urandom_range(0, 3) == 0);
            end
            // Once mid-run the sender waits for the pipeline to empty.
            if (phase == RANDOM_PHASES / 2 && n == PHASE_EVENTS / 2) hold_until_drained();
            send_event(draw_event());
         end
      end

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);

      failures = book.mismatches + book.strays + book.due_decisions.size();
      $display("Checked %0d decisions from %0d events across %0d register settings.",
               book.checked, events_sent, settings_used);
      $display("Decisions seen: %0d no network, %0d circuit open, %0d backing off.",
               book.per_state[ST_NO_NETWORK], book.per_state[ST_CIRCUIT_OPEN],
               book.per_state[ST_BACKING_OFF]);
      if (failures == 0) begin
         $display("tb_retry_backoff_recovery OK");
      end else begin
         $display("%0d mismatches, %0d unexpected, %0d missing", book.mismatches,
                  book.strays, book.due_decisions.size());
         $display("tb_retry_backoff_recovery NOT OK");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/rbr_pkg.sv
rtl/rbr_backoff.sv
rtl/retry_backoff_recovery.sv
verif/tb_retry_backoff_recovery.sv
